// ===== hw/rtl/rbu_pkg.sv =====
// Shared types and constants for the relative bearing unit.
`timescale 1ns / 1ps

package rbu_pkg;

    localparam int IN_COORD_W = 32;
    localparam int IN_ANG_W   = 16;
    localparam int OUT_ANG_W  = 16;
    localparam int OUT_TOT_W  = 17;

    localparam int ATAN_LEN = 24;
    localparam int ATAN_W   = 32;

    // atan(2^-i) as a 32-bit binary angle, rounded
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef struct packed {
        logic signed [IN_COORD_W-1:0] own_x;
        logic signed [IN_COORD_W-1:0] own_y;
        logic [IN_ANG_W-1:0]          own_heading;
        logic signed [IN_COORD_W-1:0] contact_x;
        logic signed [IN_COORD_W-1:0] contact_y;
        logic [IN_ANG_W-1:0]          contact_heading;
    } t_item;

    typedef struct packed {
        logic [OUT_ANG_W-1:0] rel_brg;
        logic [OUT_ANG_W-1:0] abs_rel_brg;
        logic [OUT_TOT_W-1:0] total_abs_rel_brg;
        logic                 coincident;
    } t_result;

endpackage

// ===== hw/rtl/relative_bearing_unit.sv =====
// Relative bearing unit: pipelined CORDIC atan2 with relative bearing folding.
`timescale 1ns / 1ps

// One item enters per clock whenever start is high and busy is low; busy is high only while reset
// is asserted. Each item gives one result on o_result with o_valid high for a single
// cycle, once it has passed through these registered stages in order: the offset
// subtract, the prescale and half-plane fold, one unrolled CORDIC vectoring stage per
// step, the bearing rounding and heading subtracts, and the fold and sum into the
// output register. Results are not held: the receiver must take each one in the cycle
// it is shown.
module relative_bearing_unit
    import rbu_pkg::*;
#(
    parameter int COORD_BITS   = 32,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    localparam int DW       = COORD_BITS + 1;
    localparam int PRESCALE = 60 - COORD_BITS;
    localparam int CW       = 64;
    localparam int ZW       = ATAN_W;
    localparam int LAT      = CORDIC_STEPS + 4;

    localparam logic [ANGLE_BITS-1:0] A_ZERO = '0;
    localparam logic [ANGLE_BITS-1:0] A_HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] A_QTR  = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] A_3QTR = {2'b11, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ZW-1:0] Z_HALF = {1'b1, {(ZW-1){1'b0}}};
    localparam logic [ZW-1:0] Z_RND  = ZW'(64'd1 << (31 - ANGLE_BITS));

    typedef struct packed {
        logic                  byp;
        logic                  same;
        logic [ANGLE_BITS-1:0] sp_ang;
        logic [ANGLE_BITS-1:0] oh;
        logic [ANGLE_BITS-1:0] ch;
    } t_side;

    function automatic logic signed [DW-1:0] coord_ext(input logic [IN_COORD_W-1:0] f);
        logic [63:0] w;
        w = {{(64-IN_COORD_W){1'b0}}, f};
        return {w[COORD_BITS-1], w[COORD_BITS-1:0]};
    endfunction

    function automatic logic [ANGLE_BITS-1:0] head_ext(input logic [IN_ANG_W-1:0] h);
        logic [31:0] w;
        w = {{(32-IN_ANG_W){1'b0}}, h};
        return w[ANGLE_BITS-1:0];
    endfunction

    assign busy = ~i_rst_n;

    // ---------------- stage 1: offset ----------------
    logic                  r1_vld;
    logic signed [DW-1:0]  r1_dx, r1_dy;
    logic [ANGLE_BITS-1:0] r1_oh, r1_ch;
    logic signed [DW-1:0]  n1_dx, n1_dy;

    assign n1_dx = coord_ext(i_item.contact_x) - coord_ext(i_item.own_x);
    assign n1_dy = coord_ext(i_item.contact_y) - coord_ext(i_item.own_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start & ~busy;
        end
        r1_dx <= n1_dx;
        r1_dy <= n1_dy;
        r1_oh <= head_ext(i_item.own_heading);
        r1_ch <= head_ext(i_item.contact_heading);
    end

    // ---------------- stage 2: axis cases, prescale, half-plane fold ----------------
    logic                 r_cvld [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_u    [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_v    [CORDIC_STEPS+1];
    logic [ZW-1:0]        r_z    [CORDIC_STEPS+1];
    t_side                r_side [CORDIC_STEPS+1];

    logic signed [CW-1:0] sc_u, sc_v;
    t_side                n_side0;

    assign sc_u = {{(CW-DW){r1_dy[DW-1]}}, r1_dy} <<< PRESCALE;
    assign sc_v = {{(CW-DW){r1_dx[DW-1]}}, r1_dx} <<< PRESCALE;

    always_comb begin
        n_side0.same = (r1_dx == '0) && (r1_dy == '0);
        n_side0.byp  = (r1_dx == '0) || (r1_dy == '0);
        n_side0.oh   = r1_oh;
        n_side0.ch   = r1_ch;
        if (r1_dx == '0) begin
            n_side0.sp_ang = (r1_dy > 0 || r1_dy == '0) ? A_ZERO : A_HALF;
        end else begin
            n_side0.sp_ang = (r1_dx > 0) ? A_QTR : A_3QTR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld[0] <= 1'b0;
        end else begin
            r_cvld[0] <= r1_vld;
        end
        r_side[0] <= n_side0;
        if (r1_dy < 0) begin
            r_u[0] <= -sc_u;
            r_v[0] <= -sc_v;
            r_z[0] <= Z_HALF;
        end else begin
            r_u[0] <= sc_u;
            r_v[0] <= sc_v;
            r_z[0] <= '0;
        end
    end

    // ---------------- CORDIC vectoring stages ----------------
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CW-1:0] sh_u, sh_v, n_u, n_v;
        logic [ZW-1:0]        n_z;
        logic                 pos;

        assign sh_u = r_u[i] >>> i;
        assign sh_v = r_v[i] >>> i;
        // zero residual rotates in the negative sense
        assign pos  = (r_v[i] > 0);
        assign n_u  = pos ? (r_u[i] + sh_v) : (r_u[i] - sh_v);
        assign n_v  = pos ? (r_v[i] - sh_u) : (r_v[i] + sh_u);
        assign n_z  = pos ? (r_z[i] + ATAN_TAB[i]) : (r_z[i] - ATAN_TAB[i]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cvld[i+1] <= 1'b0;
            end else begin
                r_cvld[i+1] <= r_cvld[i];
            end
            r_u[i+1]    <= n_u;
            r_v[i+1]    <= n_v;
            r_z[i+1]    <= n_z;
            r_side[i+1] <= r_side[i];
        end
    end

    // ---------------- bearing round and heading subtract ----------------
    t_side                 fs;
    logic [ZW-1:0]         z_rnd;
    logic [ANGLE_BITS-1:0] fwd, rev;
    logic                  r3_vld, r3_same;
    logic [ANGLE_BITS-1:0] r3_rel_o, r3_rel_c;

    assign fs    = r_side[CORDIC_STEPS];
    assign z_rnd = r_z[CORDIC_STEPS] + Z_RND;
    assign fwd   = fs.byp ? fs.sp_ang : z_rnd[ZW-1 -: ANGLE_BITS];
    assign rev   = fs.same ? A_ZERO : (fwd + A_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r_cvld[CORDIC_STEPS];
        end
        r3_same  <= fs.same;
        r3_rel_o <= fwd - fs.oh;
        r3_rel_c <= rev - fs.ch;
    end

    // ---------------- fold and sum ----------------
    logic [ANGLE_BITS-1:0] ab_o, ab_c;
    logic                  r_vld, r_coin;
    logic [ANGLE_BITS-1:0] r_rel, r_ab;
    logic [ANGLE_BITS:0]   r_tot;

    // half a turn folds to itself
    assign ab_o = (r3_rel_o <= A_HALF) ? r3_rel_o : (A_ZERO - r3_rel_o);
    assign ab_c = (r3_rel_c <= A_HALF) ? r3_rel_c : (A_ZERO - r3_rel_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r3_vld;
        end
        r_rel  <= r3_rel_o;
        r_ab   <= ab_o;
        r_tot  <= {1'b0, ab_o} + {1'b0, ab_c};
        r_coin <= r3_same;
    end

    logic [31:0] rel_w, ab_w, tot_w;

    always_comb begin
        rel_w = 32'(r_rel);
        ab_w  = 32'(r_ab);
        tot_w = 32'(r_tot);
        o_result.rel_brg           = rel_w[OUT_ANG_W-1:0];
        o_result.abs_rel_brg       = ab_w[OUT_ANG_W-1:0];
        o_result.total_abs_rel_brg = tot_w[OUT_TOT_W-1:0];
        o_result.coincident        = r_coin;
    end

    assign o_valid = r_vld;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(LAT) o_valid)
        else $error("accepted item produced no result at the pipeline latency");

    a_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ((r_rel <= A_HALF && r_ab == r_rel) ||
                   (r_rel > A_HALF && r_ab == A_ZERO - r_rel)))
        else $error("folded bearing does not match relative bearing");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_tot <= {1'b1, A_ZERO}))
        else $error("total folded bearing exceeds a full turn");
`endif

endmodule

// ===== sim/tb_relative_bearing_unit.sv =====
// Testbench for the relative bearing unit: directed geometry cases plus random tracks.
`timescale 1ns / 1ps

module tb_relative_bearing_unit;
    import rbu_pkg::*;

    localparam logic [15:0] QUARTER_TURN   = 16'h4000;
    localparam logic [15:0] HALF_TURN      = 16'h8000;
    localparam int          CORDIC_ITERS   = 16;
    localparam int          PRESCALE_SHIFT = 28;  // 60 - coordinate width
    localparam int          RANDOM_TRACKS  = 1100;
    localparam int          DRAIN_CYCLES   = 30;  // pipeline is 20 deep

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_valid;
    t_result o_result;

    t_result pending_results[$];
    int      mismatch_count = 0;
    bit      gaps_on = 1'b1;

    relative_bearing_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Compass bearing of (dx, dy), clockwise from north, rounded to 16 bits.
    function automatic logic [15:0] compass_bearing(input longint dx, input longint dy,
                                                    output bit same);
        longint      north, east, nxt_north, nxt_east;
        logic [31:0] acc;
        same = 1'b0;
        acc  = '0;
        if (dx == 0 && dy == 0) begin
            same = 1'b1;
            return '0;
        end
        if (dx == 0) return (dy > 0) ? 16'h0000 : HALF_TURN;
        if (dy == 0) return (dx > 0) ? QUARTER_TURN : HALF_TURN + QUARTER_TURN;
        north = dy <<< PRESCALE_SHIFT;
        east  = dx <<< PRESCALE_SHIFT;
        // southern half-plane: rotate by half a turn first
        if (north < 0) begin
            north = -north;
            east  = -east;
            acc   = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            // zero residual rotates in the negative sense
            if (east > 0) begin
                nxt_north = north + (east >>> i);
                nxt_east  = east - (north >>> i);
                acc       = acc + ATAN_TAB[i];
            end else begin
                nxt_north = north - (east >>> i);
                nxt_east  = east + (north >>> i);
                acc       = acc - ATAN_TAB[i];
            end
            north = nxt_north;
            east  = nxt_east;
        end
        acc = acc + 32'h0000_8000;
        return acc[31:16];
    endfunction

    function automatic logic [15:0] fold_half(input logic [15:0] a);
        return (a <= HALF_TURN) ? a : 16'h0000 - a;
    endfunction

    function automatic t_result predict_bearing(input t_item it);
        longint      dx, dy;
        bit          same;
        logic [15:0] fwd, rev, rel_own, rel_con, fold_own, fold_con;
        t_result     r;
        dx = longint'($signed(it.contact_x)) - longint'($signed(it.own_x));
        dy = longint'($signed(it.contact_y)) - longint'($signed(it.own_y));
        fwd      = compass_bearing(dx, dy, same);
        rev      = same ? 16'h0000 : fwd + HALF_TURN;
        rel_own  = fwd - it.own_heading;
        rel_con  = rev - it.contact_heading;
        fold_own = fold_half(rel_own);
        fold_con = fold_half(rel_con);
        r.rel_brg           = rel_own;
        r.abs_rel_brg       = fold_own;
        r.total_abs_rel_brg = {1'b0, fold_own} + {1'b0, fold_con};
        r.coincident        = same;
        return r;
    endfunction

    function automatic t_item make_item(input logic signed [31:0] ox, oy,
                                        input logic [15:0] oh,
                                        input logic signed [31:0] cx, cy,
                                        input logic [15:0] ch);
        t_item it;
        it.own_x           = ox;
        it.own_y           = oy;
        it.own_heading     = oh;
        it.contact_x       = cx;
        it.contact_y       = cy;
        it.contact_heading = ch;
        return it;
    endfunction

    function automatic t_item junk_item();
        return make_item($urandom, $urandom, 16'($urandom), $urandom, $urandom, 16'($urandom));
    endfunction

    // Drive one item and wait for its transfer; expectation is queued on acceptance.
    task automatic send_item(input t_item it);
        while (gaps_on && $urandom_range(99) < 19) begin
            start  <= 1'b0;
            i_item <= junk_item();
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_bearing(it));
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %p", o_result);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.rel_brg !== want.rel_brg) begin
                    $error("rel_brg: expected %0d, got %0d",
                           want.rel_brg, o_result.rel_brg);
                    mismatch_count++;
                end
                if (o_result.abs_rel_brg !== want.abs_rel_brg) begin
                    $error("abs_rel_brg: expected %0d, got %0d",
                           want.abs_rel_brg, o_result.abs_rel_brg);
                    mismatch_count++;
                end
                if (o_result.total_abs_rel_brg !== want.total_abs_rel_brg) begin
                    $error("total_abs_rel_brg: expected %0d, got %0d",
                           want.total_abs_rel_brg, o_result.total_abs_rel_brg);
                    mismatch_count++;
                end
                if (o_result.coincident !== want.coincident) begin
                    $error("coincident: expected %0d, got %0d",
                           want.coincident, o_result.coincident);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_axis_bearings();
        send_item(make_item(0, 0, 16'h0000, 0, 5, 16'h0000));
        send_item(make_item(0, 0, QUARTER_TURN, 7, 0, 16'h1234));
        send_item(make_item(10, 10, 16'hFFFF, 10, -3, 16'h8001));
        send_item(make_item(0, 0, 16'h0001, -9, 0, 16'hC000));
        send_item(make_item(COORD_MIN, 0, 16'h7FFF, COORD_MAX, 0, 16'h0000));
        send_item(make_item(0, COORD_MAX, 16'h0000, 0, COORD_MIN, 16'hFFFF));
    endtask

    task automatic test_coincident_points();
        send_item(make_item(0, 0, 16'hFFFF, 0, 0, 16'h0001));
        send_item(make_item(COORD_MIN, COORD_MAX, 16'h8000, COORD_MIN, COORD_MAX, 16'h8000));
    endtask

    task automatic test_coordinate_extremes();
        send_item(make_item(COORD_MIN, COORD_MIN, 16'hFFFF, COORD_MAX, COORD_MAX, 16'h0000));
        send_item(make_item(COORD_MAX, COORD_MAX, 16'h0000, COORD_MIN, COORD_MIN, 16'hFFFF));
        send_item(make_item(COORD_MAX, COORD_MIN, 16'hAAAA, COORD_MIN, COORD_MAX, 16'h5555));
        send_item(make_item(COORD_MIN, COORD_MAX, 16'h5555, COORD_MAX, COORD_MIN, 16'hAAAA));
    endtask

    // equal |dx| and |dy| leave a zero residual after the first iteration
    task automatic test_diagonals();
        send_item(make_item(0, 0, 16'h0000, 1, 1, 16'h0000));
        send_item(make_item(0, 0, 16'h2000, -1, -1, 16'h6000));
        send_item(make_item(0, 0, 16'h0000, 1, -1, 16'h0000));
        send_item(make_item(0, 0, 16'hE000, 32'sh4000_0000, 32'sh4000_0000, 16'h0000));
    endtask

    task automatic test_half_turn_fold();
        t_item   it;
        t_result pr;
        // due south, heading north: both folds land on half a turn
        send_item(make_item(0, 0, 16'h0000, 0, -100, HALF_TURN));
        it = make_item(0, 0, 16'h0000, 3, -7, 16'h0000);
        pr = predict_bearing(it);
        it.own_heading     = pr.rel_brg + HALF_TURN;
        pr = predict_bearing(it);
        it.contact_heading = pr.rel_brg + it.own_heading;
        send_item(it);
    endtask

    function automatic t_item random_track();
        t_item   it;
        int      span;
        t_result pr;
        it = junk_item();
        case ($urandom_range(9))
            4, 5, 6: begin
                span = ($urandom_range(1)) ? 1000 : (1 << 20);
                it.contact_x = it.own_x + (int'($urandom_range(2 * span)) - span);
                it.contact_y = it.own_y + (int'($urandom_range(2 * span)) - span);
            end
            7: begin
                if ($urandom_range(1)) it.contact_x = it.own_x;
                else it.contact_y = it.own_y;
            end
            8: begin
                it.contact_x = it.own_x;
                it.contact_y = it.own_y;
            end
            9: begin
                span = int'($urandom_range(1 << 24)) + 1;
                it.contact_x = it.own_x + (($urandom_range(1)) ? span : -span);
                it.contact_y = it.own_y + (($urandom_range(1)) ? span : -span);
                if ($urandom_range(1)) begin
                    it.own_heading = 16'h0000;
                    pr = predict_bearing(it);
                    it.own_heading = pr.rel_brg + HALF_TURN;
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic test_random_tracks();
        for (int n = 0; n < RANDOM_TRACKS; n++) begin
            gaps_on = !(n >= 400 && n < 700);
            send_item(random_track());
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_axis_bearings();
        test_coincident_points();
        test_coordinate_extremes();
        test_diagonals();
        test_half_turn_fold();
        test_random_tracks();

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[relative_bearing_unit] OK");
        end else begin
            $display("[relative_bearing_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("[relative_bearing_unit] ERROR");
        $finish;
    end

endmodule
